// ===== rtl/tpbd_pkg.sv =====
// types and constants shared by the tape pulse byte decoder
package tpbd_pkg;

   localparam int CSR_ADDR_BITS = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] TICKS_RESET = 8'd1;
   localparam logic [15:0] SHORT_MIN_RESET = 16'd150;
   localparam logic [15:0] SHORT_MAX_RESET = 16'd360;
   localparam logic [15:0] LONG_LIMIT_RESET = 16'd550;

   localparam logic [1:0] WAVE_RUN_SYNC = 2'd2;
   localparam logic [2:0] BIT_COUNT_LAST = 3'd7;

   typedef enum logic [1:0] {
      CLASS_SHORT = 2'd1,
      CLASS_LONG  = 2'd2,
      CLASS_PAUSE = 2'd3
   } pulse_class_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_BLOCK = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_EMPTY = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      REG_TICKS      = 2'd0,
      REG_SHORT_MIN  = 2'd1,
      REG_SHORT_MAX  = 2'd2,
      REG_LONG_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIV,
      FRONT_ROUND,
      FRONT_PUSH
   } front_state_type;

   typedef struct packed {
      logic [7:0]  ticks_per_us;
      logic [15:0] short_min;
      logic [15:0] short_max;
      logic [15:0] long_limit;
   } csr_type;

   typedef struct packed {
      logic            eos;
      pulse_class_type cls;
   } entry_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      data_byte;
      logic [15:0]     block_length;
      logic            last;
   } result_type;

endpackage

// ===== rtl/tpbd_front.sv =====
// front end: accepts durations, scales them by a serial divider and classifies them
module tpbd_front #(
   parameter int DELTA_BITS = 40
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [DELTA_BITS-1:0]   in_ticks,
   input  logic                    in_eos,
   input  tpbd_pkg::csr_type       csr,
   output logic                    push_valid,
   input  logic                    push_ready,
   output tpbd_pkg::entry_type     push_entry
);

   localparam int CNT_BITS = $clog2(DELTA_BITS + 1);
   localparam int LEN_BITS = DELTA_BITS + 1;

   tpbd_pkg::front_state_type state_ff, state_in;
   logic [DELTA_BITS-1:0] dq_ff, dq_in;
   logic [7:0]            rem_ff, rem_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  eos_ff, eos_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;

   logic [7:0] divisor;
   logic [8:0] rem_shift;
   logic [8:0] rem_diff;
   logic       rem_ge;
   logic [8:0] round_sum;
   logic       round_up;
   logic [LEN_BITS-1:0] short_min_ext;
   logic [LEN_BITS-1:0] short_max_ext;
   logic [LEN_BITS-1:0] long_limit_ext;
   tpbd_pkg::pulse_class_type cls;

   assign divisor = (csr.ticks_per_us == 8'd0) ? 8'd1 : csr.ticks_per_us;
   assign rem_shift = {rem_ff, dq_ff[DELTA_BITS-1]};
   assign rem_ge = rem_shift >= {1'b0, divisor};
   assign rem_diff = rem_shift - {1'b0, divisor};
   assign round_sum = {1'b0, rem_ff} + {2'b00, divisor[7:1]};
   assign round_up = round_sum >= {1'b0, divisor};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpbd_pkg::FRONT_IDLE: begin
            if (in_valid) begin
               state_in = in_eos ? tpbd_pkg::FRONT_PUSH : tpbd_pkg::FRONT_DIV;
            end
         end
         tpbd_pkg::FRONT_DIV: begin
            if (cnt_ff == CNT_BITS'(DELTA_BITS - 1)) begin
               state_in = tpbd_pkg::FRONT_ROUND;
            end
         end
         tpbd_pkg::FRONT_ROUND: begin
            state_in = tpbd_pkg::FRONT_PUSH;
         end
         tpbd_pkg::FRONT_PUSH: begin
            if (push_ready) begin
               state_in = tpbd_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = tpbd_pkg::FRONT_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      in_ready = (state_ff == tpbd_pkg::FRONT_IDLE);
      push_valid = (state_ff == tpbd_pkg::FRONT_PUSH);
   end

   // divider datapath
   always_comb begin
      dq_in = dq_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      eos_in = eos_ff;
      len_in = len_ff;
      case (state_ff)
         tpbd_pkg::FRONT_IDLE: begin
            dq_in = in_ticks;
            rem_in = 8'd0;
            cnt_in = '0;
            eos_in = in_eos;
         end
         tpbd_pkg::FRONT_DIV: begin
            dq_in = {dq_ff[DELTA_BITS-2:0], rem_ge};
            rem_in = rem_ge ? rem_diff[7:0] : rem_shift[7:0];
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
         tpbd_pkg::FRONT_ROUND: begin
            len_in = {1'b0, dq_ff} + LEN_BITS'(round_up);
         end
         default: begin
            len_in = len_ff;
         end
      endcase
   end

   assign short_min_ext = LEN_BITS'(csr.short_min);
   assign short_max_ext = LEN_BITS'(csr.short_max);
   assign long_limit_ext = LEN_BITS'(csr.long_limit);

   always_comb begin
      if (len_ff >= short_min_ext && len_ff <= short_max_ext) begin
         cls = tpbd_pkg::CLASS_SHORT;
      end else if (len_ff > short_max_ext && len_ff < long_limit_ext) begin
         cls = tpbd_pkg::CLASS_LONG;
      end else begin
         cls = tpbd_pkg::CLASS_PAUSE;
      end
   end

   assign push_entry.eos = eos_ff;
   assign push_entry.cls = cls;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpbd_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      eos_ff <= eos_in;
      len_ff <= len_in;
   end

endmodule

// ===== rtl/tpbd_queue.sv =====
// short queue of classified pulses between front and back
module tpbd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tpbd_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tpbd_pkg::entry_type pop_entry
);

   localparam int PTR_BITS = (tpbd_pkg::QUEUE_DEPTH > 1) ? $clog2(tpbd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(tpbd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(tpbd_pkg::QUEUE_DEPTH - 1);

   tpbd_pkg::entry_type entries_ff [tpbd_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign push_ready = (count_ff != CNT_BITS'(tpbd_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/tpbd_back.sv =====
// back end: wave pairing, bit shifting, block accounting and result buffering
module tpbd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  tpbd_pkg::entry_type  pop_entry,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tpbd_pkg::result_type out_result
);

   logic                      first_skipped_ff, first_skipped_in;
   tpbd_pkg::pulse_class_type prev_class_ff, prev_class_in;
   logic                      parity_ff, parity_in;
   logic [1:0]                wave_run_ff, wave_run_in;
   logic [2:0]                bit_cnt_ff, bit_cnt_in;
   logic [7:0]                shift_ff, shift_in;
   logic [15:0]               block_bytes_ff, block_bytes_in;
   logic                      any_block_ff, any_block_in;
   logic                      block_open_ff, block_open_in;

   logic                      out_valid_ff, out_valid_in;
   tpbd_pkg::result_type      out_ff, out_in;
   logic                      pend_valid_ff, pend_valid_in;
   tpbd_pkg::result_type      pend_ff, pend_in;

   logic                      slot_free;
   logic                      pop;
   logic                      take;
   logic [1:0]                n_results;
   tpbd_pkg::result_type      res0;
   tpbd_pkg::result_type      res1;
   logic                      is_short;
   logic                      is_long;
   logic [1:0]                run_next;

   assign take = out_valid_ff && out_ready;
   assign slot_free = !pend_valid_ff && (!out_valid_ff || out_ready);
   assign pop_ready = slot_free;
   assign pop = pop_valid && slot_free;

   assign is_short = (prev_class_ff == tpbd_pkg::CLASS_SHORT) &&
                     (pop_entry.cls == tpbd_pkg::CLASS_SHORT);
   assign is_long = (prev_class_ff == tpbd_pkg::CLASS_LONG) &&
                    (pop_entry.cls == tpbd_pkg::CLASS_LONG);

   always_comb begin
      if (is_short || is_long) begin
         run_next = (wave_run_ff == tpbd_pkg::WAVE_RUN_SYNC) ? wave_run_ff
                                                            : wave_run_ff + 2'd1;
      end else begin
         run_next = 2'd0;
      end
   end

   // stream state update
   always_comb begin
      first_skipped_in = first_skipped_ff;
      prev_class_in = prev_class_ff;
      parity_in = parity_ff;
      wave_run_in = wave_run_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in = shift_ff;
      block_bytes_in = block_bytes_ff;
      any_block_in = any_block_ff;
      block_open_in = block_open_ff;
      n_results = 2'd0;
      res0 = '{kind: tpbd_pkg::KIND_BYTE, data_byte: 8'd0, block_length: 16'd0, last: 1'b1};
      res1 = '{kind: tpbd_pkg::KIND_DONE, data_byte: 8'd0, block_length: 16'd0, last: 1'b1};
      if (pop) begin
         if (pop_entry.eos) begin
            if (first_skipped_ff && block_open_ff) begin
               res0.kind = tpbd_pkg::KIND_BLOCK;
               res0.block_length = block_bytes_ff;
               res0.last = 1'b0;
               n_results = 2'd2;
            end else begin
               res0.kind = any_block_ff ? tpbd_pkg::KIND_DONE : tpbd_pkg::KIND_EMPTY;
               n_results = 2'd1;
            end
            first_skipped_in = 1'b0;
            prev_class_in = tpbd_pkg::CLASS_PAUSE;
            parity_in = 1'b0;
            wave_run_in = 2'd0;
            bit_cnt_in = 3'd0;
            shift_in = 8'd0;
            block_bytes_in = 16'd0;
            any_block_in = 1'b0;
            block_open_in = 1'b0;
         end else if (!first_skipped_ff) begin
            first_skipped_in = 1'b1;
         end else begin
            prev_class_in = pop_entry.cls;
            if (pop_entry.cls == tpbd_pkg::CLASS_PAUSE) begin
               parity_in = 1'b0;
               wave_run_in = 2'd0;
               if (block_open_ff) begin
                  res0.kind = tpbd_pkg::KIND_BLOCK;
                  res0.block_length = block_bytes_ff;
                  n_results = 2'd1;
                  any_block_in = 1'b1;
               end
               block_bytes_in = 16'd0;
               block_open_in = 1'b0;
               bit_cnt_in = 3'd0;
            end else begin
               parity_in = !parity_ff;
               if (parity_ff) begin
                  wave_run_in = run_next;
                  if (run_next == tpbd_pkg::WAVE_RUN_SYNC) begin
                     shift_in = {shift_ff[6:0], is_long};
                     bit_cnt_in = bit_cnt_ff + 3'd1;
                     if (bit_cnt_ff == tpbd_pkg::BIT_COUNT_LAST) begin
                        block_bytes_in = block_bytes_ff + 16'd1;
                        block_open_in = 1'b1;
                        res0.kind = tpbd_pkg::KIND_BYTE;
                        res0.data_byte = {shift_ff[6:0], is_long};
                        n_results = 2'd1;
                     end
                  end
               end
            end
         end
      end
   end

   // result buffer
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      if (pend_valid_ff) begin
         if (take) begin
            out_in = pend_ff;
            out_valid_in = 1'b1;
            pend_valid_in = 1'b0;
         end
      end else begin
         if (take) begin
            out_valid_in = 1'b0;
         end
         if (n_results != 2'd0) begin
            out_in = res0;
            out_valid_in = 1'b1;
            if (n_results == 2'd2) begin
               pend_in = res1;
               pend_valid_in = 1'b1;
            end
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_result = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_skipped_ff <= 1'b0;
         prev_class_ff <= tpbd_pkg::CLASS_PAUSE;
         parity_ff <= 1'b0;
         wave_run_ff <= 2'd0;
         bit_cnt_ff <= 3'd0;
         shift_ff <= 8'd0;
         block_bytes_ff <= 16'd0;
         any_block_ff <= 1'b0;
         block_open_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         first_skipped_ff <= first_skipped_in;
         prev_class_ff <= prev_class_in;
         parity_ff <= parity_in;
         wave_run_ff <= wave_run_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff <= shift_in;
         block_bytes_ff <= block_bytes_in;
         any_block_ff <= any_block_in;
         block_open_ff <= block_open_in;
         out_valid_ff <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      pend_ff <= pend_in;
   end

endmodule

// ===== rtl/tape_pulse_byte_decoder_unit.sv =====
// top level of the tape pulse byte decoder: csr block, front end, queue and back end
// a duration passes the divide, round and push states of the front end, then the queue and
// the back end; an end of stream transaction goes straight to the push state
// the front end takes a new duration only once it has pushed the last one; its divider
// produces one quotient bit per cycle
// reset: synchronous; registers return to their defaults, stream state clears, queue empties
module tape_pulse_byte_decoder_unit #(
   parameter int DELTA_BITS = 40
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [39:0]                        req_pulse_ticks,
   input  logic                               req_end_of_stream,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_result_kind,
   output logic [7:0]                         rsp_data_byte,
   output logic [15:0]                        rsp_block_length,
   output logic                               rsp_last_result,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tpbd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   tpbd_pkg::csr_type       csr_ff, csr_in;
   tpbd_pkg::csr_index_type csr_index;
   logic                    csr_write;
   logic [DELTA_BITS-1:0]   ticks;
   logic                    push_valid;
   logic                    push_ready;
   tpbd_pkg::entry_type     push_entry;
   logic                    pop_valid;
   logic                    pop_ready;
   tpbd_pkg::entry_type     pop_entry;
   tpbd_pkg::result_type    result;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = tpbd_pkg::csr_index_type'(csr_paddr[tpbd_pkg::CSR_ADDR_BITS-1:2]);

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (csr_index)
            tpbd_pkg::REG_TICKS:      csr_in.ticks_per_us = csr_pwdata[7:0];
            tpbd_pkg::REG_SHORT_MIN:  csr_in.short_min = csr_pwdata[15:0];
            tpbd_pkg::REG_SHORT_MAX:  csr_in.short_max = csr_pwdata[15:0];
            tpbd_pkg::REG_LONG_LIMIT: csr_in.long_limit = csr_pwdata[15:0];
            default:                  csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tpbd_pkg::REG_TICKS:      csr_prdata = {24'd0, csr_ff.ticks_per_us};
         tpbd_pkg::REG_SHORT_MIN:  csr_prdata = {16'd0, csr_ff.short_min};
         tpbd_pkg::REG_SHORT_MAX:  csr_prdata = {16'd0, csr_ff.short_max};
         tpbd_pkg::REG_LONG_LIMIT: csr_prdata = {16'd0, csr_ff.long_limit};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.ticks_per_us <= tpbd_pkg::TICKS_RESET;
         csr_ff.short_min <= tpbd_pkg::SHORT_MIN_RESET;
         csr_ff.short_max <= tpbd_pkg::SHORT_MAX_RESET;
         csr_ff.long_limit <= tpbd_pkg::LONG_LIMIT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign ticks = DELTA_BITS'(req_pulse_ticks);

   tpbd_front #(
      .DELTA_BITS(DELTA_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_ticks   (ticks),
      .in_eos     (req_end_of_stream),
      .csr        (csr_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   tpbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   tpbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_result_kind = result.kind;
   assign rsp_data_byte = result.data_byte;
   assign rsp_block_length = result.block_length;
   assign rsp_last_result = result.last;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == tpbd_pkg::KIND_DONE ||
                    rsp_result_kind == tpbd_pkg::KIND_EMPTY) |-> rsp_last_result)
      else $error("stream end transaction not marked last");

   a_not_last_is_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> rsp_result_kind == tpbd_pkg::KIND_BLOCK)
      else $error("only a block end may precede another result of one transaction");

   a_byte_only_on_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != tpbd_pkg::KIND_BYTE |-> rsp_data_byte == 8'd0)
      else $error("data byte set on a non-data transaction");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("front end took a second transaction while busy");

endmodule

// ===== tb/tape_pulse_byte_decoder_checker.sv =====
// checker for the tape pulse byte decoder: follows csr writes, predicts decoded results, compares
module tape_pulse_byte_decoder_checker
   import tpbd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [39:0]              req_pulse_ticks,
   input  logic                     req_end_of_stream,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [1:0]               rsp_result_kind,
   input  logic [7:0]               rsp_data_byte,
   input  logic [15:0]              rsp_block_length,
   input  logic                     rsp_last_result,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   input  logic [31:0]              csr_prdata,
   input  logic                     csr_pready,
   output int                       error_count,
   output int                       results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   csr_type         csr_shadow;
   logic            stream_started;
   pulse_class_type prev_class;
   logic            half_wave_odd;
   logic [1:0]      wave_run;
   logic [2:0]      bit_count;
   logic [7:0]      shift_reg;
   logic [15:0]     block_count;
   logic            block_seen;
   logic            block_open;
   result_type      results_due[$];
   int              mismatches = 0;

   task automatic clear_stream();
      stream_started = 1'b0;
      prev_class = CLASS_PAUSE;
      half_wave_odd = 1'b0;
      wave_run = 2'd0;
      bit_count = 3'd0;
      shift_reg = 8'd0;
      block_count = 16'd0;
      block_seen = 1'b0;
      block_open = 1'b0;
   endtask

   function automatic pulse_class_type pulse_class(input logic [39:0] ticks);
      logic [63:0] div;
      logic [63:0] quot;
      logic [63:0] rem;
      logic [63:0] len_us;
      div = (csr_shadow.ticks_per_us == 8'd0) ? 64'd1 : {56'd0, csr_shadow.ticks_per_us};
      quot = {24'd0, ticks} / div;
      rem = {24'd0, ticks} % div;
      len_us = quot + ((rem + div / 2 >= div) ? 64'd1 : 64'd0);
      if (len_us >= csr_shadow.short_min && len_us <= csr_shadow.short_max) return CLASS_SHORT;
      if (len_us > csr_shadow.short_max && len_us < csr_shadow.long_limit) return CLASS_LONG;
      return CLASS_PAUSE;
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("kind %0d byte %02h length %0d last %0d",
                       r.kind, r.data_byte, r.block_length, r.last);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic decode_transaction(input logic [39:0] ticks, input logic eos);
      result_type      batch[$];
      pulse_class_type cls;
      pulse_class_type last_cls;
      logic            valid_wave;
      logic            long_wave;
      if (eos) begin
         if (stream_started && block_open) begin
            batch.push_back('{KIND_BLOCK, 8'd0, block_count, 1'b0});
            block_seen = 1'b1;
         end
         batch.push_back('{block_seen ? KIND_DONE : KIND_EMPTY, 8'd0, 16'd0, 1'b0});
         clear_stream();
      end else if (!stream_started) begin
         // first duration of a stream only arms the decoder
         stream_started = 1'b1;
      end else begin
         last_cls = prev_class;
         cls = pulse_class(ticks);
         prev_class = cls;
         if (cls == CLASS_PAUSE) begin
            half_wave_odd = 1'b0;
            wave_run = 2'd0;
            if (block_open) begin
               batch.push_back('{KIND_BLOCK, 8'd0, block_count, 1'b0});
               block_seen = 1'b1;
            end
            block_count = 16'd0;
            block_open = 1'b0;
            bit_count = 3'd0;
         end else begin
            half_wave_odd = !half_wave_odd;
            if (!half_wave_odd) begin
               valid_wave = (last_cls == cls);
               long_wave = valid_wave && (cls == CLASS_LONG);
               if (!valid_wave) wave_run = 2'd0;
               else if (wave_run < WAVE_RUN_SYNC) wave_run = wave_run + 2'd1;
               // a wave carries a bit only once the run of matching waves has reached sync
               if (wave_run == WAVE_RUN_SYNC) begin
                  shift_reg = {shift_reg[6:0], long_wave};
                  if (bit_count == BIT_COUNT_LAST) begin
                     bit_count = 3'd0;
                     block_count = block_count + 16'd1;
                     block_open = 1'b1;
                     batch.push_back('{KIND_BYTE, shift_reg, 16'd0, 1'b0});
                  end else begin
                     bit_count = bit_count + 3'd1;
                  end
               end
            end
         end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) results_due.push_back(batch[i]);
   endtask

   always @(posedge clock) begin
      result_type    got;
      result_type    want;
      csr_index_type idx;
      logic [31:0]   reg_value;
      if (reset) begin
         csr_shadow = '{TICKS_RESET, SHORT_MIN_RESET, SHORT_MAX_RESET, LONG_LIMIT_RESET};
         clear_stream();
         results_due.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            idx = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
            if (csr_pwrite) begin
               case (idx)
                  REG_TICKS:      csr_shadow.ticks_per_us = csr_pwdata[7:0];
                  REG_SHORT_MIN:  csr_shadow.short_min = csr_pwdata[15:0];
                  REG_SHORT_MAX:  csr_shadow.short_max = csr_pwdata[15:0];
                  REG_LONG_LIMIT: csr_shadow.long_limit = csr_pwdata[15:0];
                  default: ;
               endcase
            end else begin
               case (idx)
                  REG_TICKS:      reg_value = {24'd0, csr_shadow.ticks_per_us};
                  REG_SHORT_MIN:  reg_value = {16'd0, csr_shadow.short_min};
                  REG_SHORT_MAX:  reg_value = {16'd0, csr_shadow.short_max};
                  default:        reg_value = {16'd0, csr_shadow.long_limit};
               endcase
               if (csr_prdata !== reg_value)
                  report_mismatch($sformatf("register %s read expected %08h actual %08h",
                                            idx.name(), reg_value, csr_prdata));
            end
         end
         if (req_valid && req_ready) decode_transaction(req_pulse_ticks, req_end_of_stream);
         if (rsp_valid && rsp_ready) begin
            got = '{result_kind_type'(rsp_result_kind), rsp_data_byte, rsp_block_length,
                    rsp_last_result};
            if (results_due.size() == 0) begin
               report_mismatch({"unexpected result: ", describe(got)});
            end else begin
               want = results_due.pop_front();
               if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                   got.block_length !== want.block_length || got.last !== want.last)
                  report_mismatch({"expected ", describe(want), ", actual ", describe(got)});
            end
         end
      end
      error_count <= mismatches;
      results_pending <= results_due.size();
   end

endmodule

// ===== tb/tape_pulse_byte_decoder_unit_tb.sv =====
// testbench top for the tape pulse byte decoder: clock, reset, stimulus, pacing and verdict
module tape_pulse_byte_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpbd_pkg::*;

   localparam int DRAIN_CYCLES = 60;
   localparam int IDLE_LIMIT = 2000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [39:0]              req_pulse_ticks = 40'd0;
   logic                     req_end_of_stream = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_result_kind;
   logic [7:0]               rsp_data_byte;
   logic [15:0]              rsp_block_length;
   logic                     rsp_last_result;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]              csr_pwdata = 32'd0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   int          result_errors;
   int          results_pending;
   int          idle_cycles = 0;
   int unsigned stall_left = 0;
   int unsigned items_sent = 0;
   bit          send_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;

   // stimulus-side copy of the registers, used to aim pulse lengths
   int unsigned cfg_ticks = TICKS_RESET;
   int unsigned cfg_short_min = SHORT_MIN_RESET;
   int unsigned cfg_short_max = SHORT_MAX_RESET;
   int unsigned cfg_long_limit = LONG_LIMIT_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tape_pulse_byte_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pulse_ticks   (req_pulse_ticks),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_block_length  (rsp_block_length),
      .rsp_last_result   (rsp_last_result),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   tape_pulse_byte_decoder_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pulse_ticks   (req_pulse_ticks),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_block_length  (rsp_block_length),
      .rsp_last_result   (rsp_last_result),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .error_count       (result_errors),
      .results_pending   (results_pending)
   );

   // result side: random stall after each transaction
   always @(posedge clock) begin
      int unsigned hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         hold = rsp_quiet ? 0 : $urandom_range(3, 0);
         stall_left <= hold;
         rsp_ready <= (hold == 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [39:0] random_ticks();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word[39:0];
   endfunction

   function automatic int unsigned pick_length(input int unsigned lo, input int unsigned hi);
      case ($urandom_range(3, 0))
         0: return lo;
         1: return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // any tick count that rounds to len_us, rounding edges favored
   function automatic logic [39:0] ticks_for_us(input int unsigned len_us);
      longint unsigned div;
      longint unsigned base;
      longint unsigned off;
      div = (cfg_ticks == 0) ? 1 : cfg_ticks;
      case ($urandom_range(3, 0))
         0: off = 0;
         1: off = div - 1;
         default: off = $urandom_range(div - 1, 0);
      endcase
      base = len_us * div;
      if (base < div / 2) return 40'(off % ((div + 1) / 2));
      return 40'(base - div / 2 + off);
   endfunction

   function automatic logic [39:0] pulse_of(input pulse_class_type cls);
      case (cls)
         CLASS_SHORT:
            if (cfg_short_min <= cfg_short_max)
               return ticks_for_us(pick_length(cfg_short_min, cfg_short_max));
         CLASS_LONG:
            if (cfg_long_limit > cfg_short_max + 1)
               return ticks_for_us(pick_length(cfg_short_max + 1, cfg_long_limit - 1));
         default:
            case ($urandom_range(2, 0))
               0: return ticks_for_us(cfg_long_limit + $urandom_range(300, 0));
               1: if (cfg_short_min > 0) return ticks_for_us($urandom_range(cfg_short_min - 1, 0));
               default: ;
            endcase
      endcase
      return random_ticks();
   endfunction

   task automatic send_item(input logic [39:0] ticks, input logic eos);
      int unsigned gap;
      gap = send_quiet ? 0 : $urandom_range(3, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pulse_ticks <= ticks;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_wave(input pulse_class_type first_half, input pulse_class_type second_half);
      send_item(pulse_of(first_half), 1'b0);
      send_item(pulse_of(second_half), 1'b0);
   endtask

   task automatic send_byte(input logic [7:0] value);
      pulse_class_type cls;
      for (int i = 7; i >= 0; i--) begin
         cls = value[i] ? CLASS_LONG : CLASS_SHORT;
         send_wave(cls, cls);
      end
   endtask

   task automatic send_block();
      pulse_class_type cls;
      repeat ($urandom_range(3, 1)) begin
         cls = $urandom_range(1, 0) ? CLASS_LONG : CLASS_SHORT;
         send_wave(cls, cls);
      end
      repeat ($urandom_range(3, 1)) begin
         case ($urandom_range(15, 0))
            // broken wave, then a fresh sync
            0: begin
               send_wave(CLASS_SHORT, CLASS_LONG);
               send_wave(CLASS_SHORT, CLASS_SHORT);
            end
            // stray half wave shifts the pairing
            1: send_item(pulse_of(CLASS_SHORT), 1'b0);
            default: ;
         endcase
         send_byte(8'($urandom_range(255, 0)));
      end
      send_item(pulse_of(CLASS_PAUSE), 1'b0);
   endtask

   task automatic send_stream();
      send_item(random_ticks(), 1'b0);
      repeat ($urandom_range(3, 1)) send_block();
      if ($urandom_range(3, 0) != 0) send_item(random_ticks(), 1'b1);
   endtask

   task automatic send_noise(input int unsigned count);
      repeat (count) begin
         case ($urandom_range(11, 0))
            0: send_item(random_ticks(), 1'b1);
            1, 2: send_item(random_ticks(), 1'b0);
            3, 4, 5: send_item(pulse_of(CLASS_SHORT), 1'b0);
            6, 7, 8: send_item(pulse_of(CLASS_LONG), 1'b0);
            default: send_item(pulse_of(CLASS_PAUSE), 1'b0);
         endcase
      end
   endtask

   task automatic wait_for_results(input bit settle);
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      // skipped durations leave no result behind, so let the pipeline empty
      if (settle) repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input csr_index_type idx, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned ticks, input int unsigned short_min,
                            input int unsigned short_max, input int unsigned long_limit);
      csr_index_type idx;
      wait_for_results(1'b1);
      cfg_ticks = ticks & 8'hff;
      cfg_short_min = short_min & 16'hffff;
      cfg_short_max = short_max & 16'hffff;
      cfg_long_limit = long_limit & 16'hffff;
      // upper data bits are junk the register must drop
      csr_access(1'b1, REG_TICKS, ($urandom & 32'hffff_ff00) | cfg_ticks);
      csr_access(1'b1, REG_SHORT_MIN, ($urandom & 32'hffff_0000) | cfg_short_min);
      csr_access(1'b1, REG_SHORT_MAX, ($urandom & 32'hffff_0000) | cfg_short_max);
      csr_access(1'b1, REG_LONG_LIMIT, ($urandom & 32'hffff_0000) | cfg_long_limit);
      idx = idx.first();
      repeat (4) begin
         csr_access(1'b0, idx, 32'd0);
         idx = idx.next();
      end
   endtask

   task automatic run_phase(input int unsigned budget);
      int unsigned stop_at;
      bit          well_formed;
      stop_at = items_sent + budget;
      well_formed = (cfg_short_min <= cfg_short_max) && (cfg_long_limit > cfg_short_max + 1);
      while (items_sent < stop_at) begin
         send_quiet = ($urandom_range(3, 0) == 0);
         rsp_quiet = ($urandom_range(3, 0) == 0);
         if (well_formed && $urandom_range(4, 0) != 0) send_stream();
         else send_noise($urandom_range(10, 3));
         if ($urandom_range(5, 0) == 0) wait_for_results(1'b0);
      end
   endtask

   initial begin
      int unsigned short_min;
      int unsigned short_max;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // end of stream before any duration, then one byte framed by pauses
      send_item(random_ticks(), 1'b1);
      send_item(40'd0, 1'b0);
      send_item(40'hff_ffff_ffff, 1'b0);
      send_item(40'd150, 1'b0);
      send_item(40'd360, 1'b0);
      send_byte(8'ha5);
      send_item(40'd550, 1'b0);
      send_item(random_ticks(), 1'b1);

      configure(0, 150, 360, 550);
      run_phase(55);
      configure(255, 0, 1000, 65535);
      run_phase(55);
      configure(3, 0, 0, 2);
      run_phase(55);
      configure(7, 10, 5, 20);
      run_phase(40);
      configure(0, 65535, 65535, 0);
      run_phase(40);
      configure(2, 150, 360, 550);
      run_phase(55);
      repeat (5) begin
         short_min = $urandom_range(400, 0);
         short_max = short_min + $urandom_range(400, 1);
         configure($urandom_range(255, 1), short_min, short_max,
                   short_max + 2 + $urandom_range(600, 0));
         run_phase(55);
      end
      configure(1, 150, 360, 550);
      run_phase(55);

      wait_for_results(1'b1);
      if (result_errors == 0 && results_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
